// File: src/acc_pkg.sv
// Shared types, opcodes and constants for the ALU and branch unit
`default_nettype none
package acc_pkg;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 16;
    localparam int KIND_W = 5;
    localparam int IDX_W  = 1;
    localparam int DEF_DIV_STEPS_PER_CYCLE = 1;

    typedef enum logic [KIND_W-1:0] {
        K_MOV = 5'd0, K_ADD = 5'd1, K_SUB = 5'd2, K_MUL = 5'd3, K_DIV = 5'd4,
        K_CMP = 5'd5, K_SHL = 5'd6, K_SHR = 5'd7, K_SAR = 5'd8, K_AND = 5'd9,
        K_OR = 5'd10, K_XOR = 5'd11, K_SWAP = 5'd12, K_LDL = 5'd13,
        K_LDH = 5'd14, K_NOT = 5'd15, K_JMP = 5'd16, K_JZ = 5'd17,
        K_JP = 5'd18, K_JN = 5'd19, K_JNZ = 5'd20, K_JNP = 5'd21,
        K_JNN = 5'd22
    } t_kind;

    localparam logic [IDX_W-1:0] REG_CODE_BASE = 1'b0;
    localparam logic [IDX_W-1:0] REG_CODE_SIZE = 1'b1;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_DIV0 = 2'd1;
    localparam logic [1:0] FAULT_JUMP = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE, S_MUL, S_DIV, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture operands, start item
        logic mul_step;   // register product
        logic div_start;
        logic div_step;
        logic finish;     // form result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_done;
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] value_a;
        logic              write_a;
        logic [DATA_W-1:0] value_b;
        logic              write_b;
        logic [DATA_W-1:0] remainder;
        logic              write_remainder;
        logic              jump_taken;
        logic              flag_negative;
        logic              flag_zero;
        logic [1:0]        fault;
    } t_result;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_item;
endpackage
`default_nettype wire

// File: src/acc_if.sv
// Valid/ready channel carrying one payload
`default_nettype none
interface acc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/acc_ctrl.sv
// Controller state machine: sequences ALU, multiply and iterative divide
`default_nettype none
module acc_ctrl import acc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_MUL: begin
                o_cmd.finish   = 1'b1;
                n_state        = S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (o_in_ready && i_in_valid) begin
            o_cmd.load = 1'b1;
            if (i_status.is_mul) begin
                // product registered on the transfer edge
                o_cmd.mul_step = 1'b1;
                n_state        = S_MUL;
            end else if (i_status.is_div) begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end else begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(o_cmd.load && r_state == S_DIV))
                else $error("item taken during divide");
            assert (!(o_cmd.finish && o_cmd.mul_step && o_cmd.load))
                else $error("multiply finish overlaps load");
        end
    end
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_ready) |=> r_state == S_OUT)
        else $error("result dropped while stalled");
    a_mul_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |=> r_state == S_OUT)
        else $error("multiply did not finish");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_DIV)
        else $error("divide not entered");
endmodule
`default_nettype wire

// File: src/acc_dp.sv
// Datapath: operand registers, ALU, multiplier, restoring divider, flags
`default_nettype none
module acc_dp import acc_pkg::*; #(
    parameter int DIV_STEPS = DEF_DIV_STEPS_PER_CYCLE
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_item            i_item,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output t_status               o_status,
    output t_result               o_result
);
    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [CFG_W-1:0]  r_base, r_size;
    logic              r_n, r_z;
    logic [KIND_W-1:0] r_kind;
    logic [DATA_W-1:0] r_a, r_b;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_q, r_rem, r_dvs;
    logic              r_neg_q, r_neg_r;
    logic [CNT_W-1:0]  r_cnt;
    t_result           r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_CODE_BASE) r_base <= i_cfg_data;
            if (i_cfg_idx == REG_CODE_SIZE) r_size <= i_cfg_data;
        end
    end

    assign o_status.is_mul   = (t_kind'(i_item.kind) == K_MUL);
    assign o_status.is_div   = (t_kind'(i_item.kind) == K_DIV) && (i_item.operand_b != '0);
    assign o_status.div_done = (r_cnt == CNT_W'(DATA_W));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_a    <= i_item.operand_a;
            r_b    <= i_item.operand_b;
        end
        if (i_cmd.mul_step) r_prod <= i_item.operand_a * i_item.operand_b;
    end

    // restoring divide on magnitudes, DIV_STEPS bits per cycle
    logic [DATA_W-1:0] ua, ub;
    assign ua = i_item.operand_a[DATA_W-1] ? -i_item.operand_a : i_item.operand_a;
    assign ub = i_item.operand_b[DATA_W-1] ? -i_item.operand_b : i_item.operand_b;

    logic [DATA_W-1:0] n_q, n_rem;
    logic [DATA_W:0]   trial;
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        trial = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            trial = {n_rem, n_q[DATA_W-1]} - {1'b0, r_dvs};
            if (!trial[DATA_W]) begin
                n_rem = trial[DATA_W-1:0];
                n_q   = {n_q[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = {n_rem[DATA_W-2:0], n_q[DATA_W-1]};
                n_q   = {n_q[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step && !o_status.div_done) begin
            r_cnt <= r_cnt + CNT_W'(DIV_STEPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_q     <= ua;
            r_rem   <= '0;
            r_dvs   <= ub;
            r_neg_q <= i_item.operand_a[DATA_W-1] ^ i_item.operand_b[DATA_W-1];
            r_neg_r <= i_item.operand_a[DATA_W-1];
        end else if (i_cmd.div_step && !o_status.div_done) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    // result forming: kinds other than MUL and DIV work straight from the input item
    logic [KIND_W-1:0] k;
    logic [DATA_W-1:0] a, b, sh, v;
    logic              setf, jfault, cond;
    logic [CFG_W:0]    hi;
    always_comb begin
        k     = i_cmd.load ? i_item.kind : r_kind;
        a     = i_cmd.load ? i_item.operand_a : r_a;
        b     = i_cmd.load ? i_item.operand_b : r_b;
        n_res = '0;
        n_res.flag_negative = r_n;
        n_res.flag_zero     = r_z;
        setf  = 1'b0;
        v     = '0;
        hi    = {1'b0, r_base} + {1'b0, r_size};
        if (b[DATA_W-1])                       sh = a;
        else if (b >= DATA_W)                  sh = (t_kind'(k) == K_SAR && a[DATA_W-1]) ? '1 : '0;
        else if (t_kind'(k) == K_SHL)          sh = a << b[4:0];
        else if (t_kind'(k) == K_SHR)          sh = a >> b[4:0];
        else                                   sh = $signed(a) >>> b[4:0];
        jfault = a[DATA_W-1] || (a < DATA_W'(r_base)) || (a > DATA_W'(hi));
        case (t_kind'(k))
            K_JMP:   cond = 1'b1;
            K_JZ:    cond = r_z;
            K_JP:    cond = !r_n && !r_z;
            K_JN:    cond = r_n && !r_z;
            K_JNZ:   cond = !r_z;
            K_JNP:   cond = r_n || r_z;
            default: cond = !r_n;
        endcase
        case (t_kind'(k))
            K_MOV: begin n_res.value_a = b; n_res.write_a = 1'b1; end
            K_ADD: begin v = a + b; setf = 1'b1; n_res.write_a = 1'b1; end
            K_SUB: begin v = a - b; setf = 1'b1; n_res.write_a = 1'b1; end
            K_MUL: begin v = r_prod; setf = 1'b1; n_res.write_a = 1'b1; end
            K_DIV: begin
                if (b == '0) begin
                    n_res.fault = FAULT_DIV0;
                end else begin
                    v = r_neg_q ? -r_q : r_q;
                    n_res.remainder = r_neg_r ? -r_rem : r_rem;
                    n_res.write_remainder = 1'b1;
                    n_res.write_a = 1'b1;
                    setf = 1'b1;
                end
            end
            K_CMP: begin v = a - b; setf = 1'b1; end
            K_SHL, K_SHR, K_SAR: begin v = sh; setf = 1'b1; n_res.write_a = 1'b1; end
            K_AND: begin v = a & b; setf = 1'b1; n_res.write_a = 1'b1; end
            K_OR:  begin v = a | b; setf = 1'b1; n_res.write_a = 1'b1; end
            K_XOR: begin v = a ^ b; setf = 1'b1; n_res.write_a = 1'b1; end
            K_NOT: begin v = ~a; setf = 1'b1; n_res.write_a = 1'b1; end
            K_SWAP: begin
                n_res.value_a = b; n_res.value_b = a;
                n_res.write_a = 1'b1; n_res.write_b = 1'b1;
            end
            K_LDL: begin n_res.value_a = {a[31:16], b[15:0]}; n_res.write_a = 1'b1; end
            K_LDH: begin n_res.value_a = {b[15:0], a[15:0]}; n_res.write_a = 1'b1; end
            K_JMP, K_JZ, K_JP, K_JN, K_JNZ, K_JNP, K_JNN: begin
                if (jfault) n_res.fault = FAULT_JUMP;
                else        n_res.jump_taken = cond;
            end
            default: ;
        endcase
        if (setf) begin
            if (t_kind'(k) != K_CMP) n_res.value_a = v;
            n_res.flag_zero     = (v == '0);
            n_res.flag_negative = v[DATA_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 1'b0;
            r_z <= 1'b0;
        end else if (i_cmd.finish) begin
            r_n <= n_res.flag_negative;
            r_z <= n_res.flag_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) r_res <= n_res;
    end
    assign o_result = r_res;

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_n && r_z)) else $error("N and Z both set");
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DATA_W)) else $error("divide counter overrun");
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.finish) && r_res.fault != FAULT_NONE |-> !r_res.write_a)
        else $error("write on fault");
endmodule
`default_nettype wire

// File: src/alu_with_condition_codes_and_branch_unit.sv
// ALU with N/Z condition codes and conditional branch: top level
// Usage: items (kind, operand_a, operand_b) arrive on in_ch and one result
// per item leaves on out_ch; both are valid/ready, a transfer happens when
// both are high. code_base (index 0) and code_size (index 1) are written on
// the plain cfg port; the user must write them only while idle, the block itself does not enforce this.
// For most kinds the result is valid in the cycle after the transfer; MUL
// registers the 32x32 product on the transfer edge, then forms the result in
// S_MUL; DIV with a nonzero divisor first runs the restoring divider in S_DIV.
// Throughput: one item per cycle for kinds other than MUL and DIV while the receiver
// keeps ready high, since the controller takes the next item in the same
// cycle as the result transfer; MUL and DIV with a nonzero divisor hold off input until done.
// Reset (synchronous, active low) clears flags, config and controller.
// When the receiver stalls, the result stays in the output register and no
// further item is accepted.
`default_nettype none
module alu_with_condition_codes_and_branch_unit import acc_pkg::*; #(
    parameter int DIV_STEPS = DEF_DIV_STEPS_PER_CYCLE
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    acc_if.sink                   in_ch,
    acc_if.source                 out_ch,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    t_cmd    cmd;
    t_status status;

    acc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    acc_dp #(.DIV_STEPS(DIV_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(in_ch.data), .i_cmd(cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_status(status), .o_result(out_ch.data)
    );
endmodule
`default_nettype wire

// File: dv/tb_alu_with_condition_codes_and_branch_unit.sv
// Testbench for the ALU with condition codes and branch unit
`timescale 1ns / 100ps
`default_nettype none
module tb_alu_with_condition_codes_and_branch_unit;
    import acc_pkg::*;

    class alu_scoreboard;
        t_result pending[$];
        logic [1:0] nz_flags;
        logic [15:0] seg_base;
        logic [15:0] seg_size;
        int mismatches;

        function void clear();
            pending.delete();
            nz_flags = 2'b00;
            seg_base = '0;
            seg_size = '0;
            mismatches = 0;
        endfunction

        function void update_nz(logic [31:0] v);
            if (v == 32'd0) nz_flags = 2'b01;
            else if (v[31]) nz_flags = 2'b10;
            else nz_flags = 2'b00;
        endfunction

        function void note_item(t_item it);
            t_result r;
            logic signed [31:0] sa, sb;
            logic signed [63:0] tgt, hi;
            logic nf, zf, cond;
            r = '0;
            sa = it.operand_a;
            sb = it.operand_b;
            case (it.kind)
                K_MOV: begin r.value_a = sb; r.write_a = 1'b1; end
                K_ADD: begin r.value_a = sa + sb; r.write_a = 1'b1; update_nz(r.value_a); end
                K_SUB: begin r.value_a = sa - sb; r.write_a = 1'b1; update_nz(r.value_a); end
                K_MUL: begin r.value_a = sa * sb; r.write_a = 1'b1; update_nz(r.value_a); end
                K_DIV: begin
                    if (sb == 0) r.fault = FAULT_DIV0;
                    else if (sa == 32'sh80000000 && sb == -1) begin
                        r.value_a = 32'h80000000; r.remainder = 32'd0;
                        r.write_a = 1'b1; r.write_remainder = 1'b1;
                        update_nz(r.value_a);
                    end else begin
                        r.value_a = sa / sb; r.remainder = sa % sb;
                        r.write_a = 1'b1; r.write_remainder = 1'b1;
                        update_nz(r.value_a);
                    end
                end
                K_CMP: update_nz(sa - sb);
                K_SHL, K_SHR, K_SAR: begin
                    if (sb[31]) r.value_a = sa;
                    else if (sb >= 32)
                        r.value_a = (it.kind == K_SAR) ? {32{sa[31]}} : 32'd0;
                    else if (it.kind == K_SHL) r.value_a = sa << sb[4:0];
                    else if (it.kind == K_SHR) r.value_a = sa >> sb[4:0];
                    else r.value_a = sa >>> sb[4:0];
                    r.write_a = 1'b1; update_nz(r.value_a);
                end
                K_AND: begin r.value_a = sa & sb; r.write_a = 1'b1; update_nz(r.value_a); end
                K_OR: begin r.value_a = sa | sb; r.write_a = 1'b1; update_nz(r.value_a); end
                K_XOR: begin r.value_a = sa ^ sb; r.write_a = 1'b1; update_nz(r.value_a); end
                K_NOT: begin r.value_a = ~sa; r.write_a = 1'b1; update_nz(r.value_a); end
                K_SWAP: begin
                    r.value_a = sb; r.value_b = sa; r.write_a = 1'b1; r.write_b = 1'b1;
                end
                K_LDL: begin r.value_a = {sa[31:16], sb[15:0]}; r.write_a = 1'b1; end
                K_LDH: begin r.value_a = {sb[15:0], sa[15:0]}; r.write_a = 1'b1; end
                K_JMP, K_JZ, K_JP, K_JN, K_JNZ, K_JNP, K_JNN: begin
                    tgt = sa;
                    hi = 64'(seg_base) + 64'(seg_size);
                    nf = nz_flags[1];
                    zf = nz_flags[0];
                    if (tgt < $signed(64'(seg_base)) || tgt > hi) r.fault = FAULT_JUMP;
                    else begin
                        case (it.kind)
                            K_JMP: cond = 1'b1;
                            K_JZ: cond = zf;
                            K_JP: cond = !nf && !zf;
                            K_JN: cond = nf && !zf;
                            K_JNZ: cond = !zf;
                            K_JNP: cond = nf || zf;
                            default: cond = !nf;
                        endcase
                        r.jump_taken = cond;
                    end
                end
                default: ;
            endcase
            r.flag_negative = nz_flags[1];
            r.flag_zero = nz_flags[0];
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h got %h", exp_r, got);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [15:0] PH_BASES[4] = '{16'd0, 16'hFFFF, 16'd100, 16'd0};
    localparam logic [15:0] PH_SIZES[4] = '{16'hFFFF, 16'hFFFF, 16'd50, 16'd0};

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    int cycles = 0;
    int long_hold = 0;
    bit rx_enable = 0;
    alu_scoreboard sb_alu;

    acc_if #(.T(t_item)) in_ch ();
    acc_if #(.T(t_result)) out_ch ();

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    alu_with_condition_codes_and_branch_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!rx_enable) out_ch.ready <= 0;
        else if (long_hold > 0) begin
            out_ch.ready <= 0;
            long_hold <= long_hold - 1;
        end else if (cycles % 512 < 128) out_ch.ready <= 1;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
        if (i_rst_n && out_ch.valid && out_ch.ready) sb_alu.check_result(out_ch.data);
    end

    // inputs accepted at this edge go to the predictor
    always @(posedge i_clk)
        if (i_rst_n && in_ch.valid && in_ch.ready) sb_alu.note_item(in_ch.data);

    int burst_left = 0;

    // call in step with the clock; returns once the item has been accepted
    task automatic send_item(t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        // the next call either re-drives valid or the caller lowers it
    endtask

    task automatic stop_sending();
        in_ch.valid <= 0;
    endtask

    task automatic drain();
        stop_sending();
        while (sb_alu.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_CODE_BASE) sb_alu.seg_base = val;
        else sb_alu.seg_size = val;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(0, 3) - 1;
            3: return $urandom_range(0, 70);
            4: return -$urandom_range(0, 70);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.kind = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(23, 31))
                                               : 5'($urandom_range(0, 22));
        it.operand_a = rand_operand();
        it.operand_b = rand_operand();
        if (it.kind >= K_JMP && it.kind <= K_JNN && $urandom_range(0, 3) != 0)
            it.operand_a = sb_alu.seg_base + $urandom_range(0, sb_alu.seg_size + 2);
        return it;
    endfunction

    function automatic t_item mk(t_kind k, logic [31:0] a, logic [31:0] b);
        t_item it;
        it.kind = k;
        it.operand_a = a;
        it.operand_b = b;
        return it;
    endfunction

    initial begin
        sb_alu = new();
        sb_alu.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        rx_enable = 1;
        write_cfg(REG_CODE_BASE, 16'd10);
        write_cfg(REG_CODE_SIZE, 16'd20);
        // directed corner cases
        send_item(mk(K_JMP, 32'd10, 0));
        send_item(mk(K_JZ, 32'd30, 0));
        send_item(mk(K_JMP, 32'd31, 0));
        send_item(mk(K_JMP, 32'd9, 0));
        send_item(mk(K_JMP, 32'hFFFFFFFF, 0));
        send_item(mk(K_ADD, 32'h7FFFFFFF, 32'd1));
        send_item(mk(K_JN, 32'd12, 0));
        send_item(mk(K_SUB, 32'd5, 32'd5));
        send_item(mk(K_JNP, 32'd12, 0));
        send_item(mk(K_MUL, 32'hFFFFFFFF, 32'h80000000));
        send_item(mk(K_DIV, 32'd7, 32'd0));
        send_item(mk(K_DIV, 32'h80000000, 32'hFFFFFFFF));
        send_item(mk(K_DIV, 32'hFFFFFFF9, 32'd2));
        send_item(mk(K_SHL, 32'hFFFFFFFF, 32'd32));
        send_item(mk(K_SHR, 32'h80000000, 32'd31));
        send_item(mk(K_SAR, 32'h80000000, 32'd100));
        send_item(mk(K_SAR, 32'h80000000, 32'hFFFFFFFF));
        send_item(mk(K_CMP, 32'd1, 32'd2));
        send_item(mk(K_JNN, 32'd15, 0));
        send_item(mk(K_SWAP, 32'h12345678, 32'h9ABCDEF0));
        send_item(mk(K_LDL, 32'hFFFF0000, 32'h1234ABCD));
        send_item(mk(K_LDH, 32'h0000FFFF, 32'h1234ABCD));
        send_item(mk(K_NOT, 32'hFFFFFFFF, 32'd3));
        send_item(mk(K_MOV, 32'd1, 32'h7FFFFFFF));
        send_item(mk(t_kind'(5'd31), 32'd1, 32'd2));
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(REG_CODE_BASE, PH_BASES[ph]);
            write_cfg(REG_CODE_SIZE, PH_SIZES[ph]);
            for (int n = 0; n < 500; n++) begin
                if (ph == 1 && n == 100) long_hold = 300;
                send_item(rand_item());
            end
            drain();
        end
        if (sb_alu.mismatches == 0 && sb_alu.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
